// ----- sv/lmss_pkg.sv -----
package lmss_pkg;

	// Geometry of the matrix and of one glyph.
	localparam int LMSS_MAX_GLYPHS = 14;
	localparam int LMSS_ROWS       = 8;
	localparam int LMSS_COLS       = 8;

	// Register reset values.
	localparam logic [3:0]  LMSS_COUNT_RESET  = 4'd4;
	localparam logic [15:0] LMSS_PERIOD_RESET = 16'd40;
	localparam logic        LMSS_ENABLE_RESET = 1'b1;

	// Configuration port.
	localparam int LMSS_ADDR_W = 4;
	localparam int LMSS_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_GLYPH_COUNT    = 2'd0,
		REG_SCROLL_PERIOD  = 2'd1,
		REG_DISPLAY_ENABLE = 2'd2
	} lmss_reg_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_TICK  = 1'b1
	} lmss_action_t;

	typedef struct packed {
		logic       action;
		logic [3:0] glyph_slot;
		logic [2:0] glyph_row;
		logic [7:0] glyph_byte;
	} lmss_in_t;

	typedef struct packed {
		logic [7:0] column_select_n;
		logic [7:0] row_drive;
	} lmss_out_t;

	typedef struct packed {
		logic [3:0]  glyph_count;
		logic [15:0] scroll_period_ticks;
		logic        display_enable;
	} lmss_cfg_t;

	typedef struct packed {
		logic       en;
		logic [3:0] slot;
		logic [2:0] row;
		logic [7:0] data;
	} lmss_wr_t;

endpackage

// ----- sv/lmss_ram.sv -----
module lmss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write-first: a read of the address being written returns the new data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= (we && waddr == raddr_a) ? wdata : mem_q[raddr_a];
		rdata_b <= (we && waddr == raddr_b) ? wdata : mem_q[raddr_b];
	end

endmodule

// ----- sv/lmss_glyph_store.sv -----
module lmss_glyph_store #(
	parameter int MAX_GLYPHS = lmss_pkg::LMSS_MAX_GLYPHS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lmss_pkg::lmss_wr_t                    wr,
	input  logic [$clog2(MAX_GLYPHS+2)-1:0]       cur_slot,
	input  logic [$clog2(MAX_GLYPHS+2)-1:0]       nxt_slot,
	output logic [lmss_pkg::LMSS_ROWS-1:0][7:0]   cur_rows,
	output logic [lmss_pkg::LMSS_ROWS-1:0][7:0]   nxt_rows
);
	import lmss_pkg::*;

	localparam int SLOTS  = MAX_GLYPHS + 2;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CMP_W  = (SLOT_W > 4) ? SLOT_W + 1 : 5;

	logic [SLOTS-1:0][LMSS_ROWS-1:0] valid_q;
	logic [LMSS_ROWS-1:0]            cur_ok_q;
	logic [LMSS_ROWS-1:0]            nxt_ok_q;
	logic                            wr_hit;
	logic [SLOT_W-1:0]               wslot;
	logic [LMSS_ROWS-1:0]            row_we;
	logic [LMSS_ROWS-1:0][7:0]       cur_raw;
	logic [LMSS_ROWS-1:0][7:0]       nxt_raw;

	// Slot zero is the leading blank and is never written.
	assign wr_hit = wr.en && (wr.slot != 4'd0)
		&& (CMP_W'(wr.slot) <= CMP_W'(MAX_GLYPHS));
	assign wslot = SLOT_W'(wr.slot);

	always_comb begin
		for (int r = 0; r < LMSS_ROWS; r++) begin
			row_we[r] = wr_hit && (wr.row == 3'(r));
		end
	end

	// One memory per glyph row, so a scroll step sees all rows of two slots.
	for (genvar r = 0; r < LMSS_ROWS; r++) begin : g_row
		lmss_ram #(
			.WIDTH (8),
			.DEPTH (SLOTS)
		) u_ram (
			.clk     (clk),
			.we      (row_we[r]),
			.waddr   (wslot),
			.wdata   (wr.data),
			.raddr_a (cur_slot),
			.rdata_a (cur_raw[r]),
			.raddr_b (nxt_slot),
			.rdata_b (nxt_raw[r])
		);
	end

	// Valid bits stand in for clearing the store at reset. They are sampled
	// alongside the read data so that both describe the same access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			cur_ok_q <= '0;
			nxt_ok_q <= '0;
		end else begin
			for (int r = 0; r < LMSS_ROWS; r++) begin
				if (row_we[r]) begin
					valid_q[wslot][r] <= 1'b1;
				end
				cur_ok_q[r] <= valid_q[cur_slot][r] || (row_we[r] && wslot == cur_slot);
				nxt_ok_q[r] <= valid_q[nxt_slot][r] || (row_we[r] && wslot == nxt_slot);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < LMSS_ROWS; r++) begin
			cur_rows[r] = cur_ok_q[r] ? cur_raw[r] : 8'h00;
			nxt_rows[r] = nxt_ok_q[r] ? nxt_raw[r] : 8'h00;
		end
	end

endmodule

// ----- sv/lmss_cfg_regs.sv -----
module lmss_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lmss_pkg::LMSS_ADDR_W-1:0]  paddr,
	input  logic [lmss_pkg::LMSS_DATA_W-1:0]  pwdata,
	output logic [lmss_pkg::LMSS_DATA_W-1:0]  prdata,
	output logic                              pready,
	output lmss_pkg::lmss_cfg_t               cfg
);
	import lmss_pkg::*;

	lmss_cfg_t cfg_q;
	lmss_reg_t reg_sel;
	logic      wr_en;

	assign reg_sel = lmss_reg_t'(paddr[LMSS_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_count         <= LMSS_COUNT_RESET;
			cfg_q.scroll_period_ticks <= LMSS_PERIOD_RESET;
			cfg_q.display_enable      <= LMSS_ENABLE_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_GLYPH_COUNT: begin
					cfg_q.glyph_count <= pwdata[3:0];
				end
				REG_SCROLL_PERIOD: begin
					cfg_q.scroll_period_ticks <= pwdata[15:0];
				end
				REG_DISPLAY_ENABLE: begin
					cfg_q.display_enable <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GLYPH_COUNT: begin
				prdata = LMSS_DATA_W'(cfg_q.glyph_count);
			end
			REG_SCROLL_PERIOD: begin
				prdata = LMSS_DATA_W'(cfg_q.scroll_period_ticks);
			end
			REG_DISPLAY_ENABLE: begin
				prdata = LMSS_DATA_W'(cfg_q.display_enable);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ----- sv/lmss_scan_core.sv -----
module lmss_scan_core #(
	parameter int MAX_GLYPHS = lmss_pkg::LMSS_MAX_GLYPHS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lmss_pkg::lmss_cfg_t                 cfg,
	input  logic                                step,
	input  logic [lmss_pkg::LMSS_ROWS-1:0][7:0] cur_rows,
	input  logic [lmss_pkg::LMSS_ROWS-1:0][7:0] nxt_rows,
	output logic [$clog2(MAX_GLYPHS+2)-1:0]     cur_slot,
	output logic [$clog2(MAX_GLYPHS+2)-1:0]     nxt_slot,
	output lmss_pkg::lmss_out_t                 result
);
	import lmss_pkg::*;

	localparam int SLOT_W = $clog2(MAX_GLYPHS + 2);
	localparam int CMP_W  = (SLOT_W > 4) ? SLOT_W + 1 : 5;

	logic [SLOT_W-1:0]         glyph_index_q;
	logic [2:0]                bit_offset_q;
	logic [2:0]                scan_column_q;
	logic [15:0]               elapsed_q;
	logic [LMSS_ROWS-1:0][7:0] frame_q;

	logic [CMP_W-1:0]          eff_count;
	logic [CMP_W-1:0]          idx_next;
	logic                      cur_blank;
	logic                      nxt_blank;
	logic [15:0]               elapsed_inc;
	logic                      scroll;
	logic [LMSS_ROWS-1:0][7:0] new_frame;
	logic [LMSS_ROWS-1:0][7:0] shown_frame;
	logic [15:0]               pair;

	assign cur_slot = glyph_index_q;
	assign nxt_slot = glyph_index_q + SLOT_W'(1);

	// A count above the store size acts as the store size.
	assign eff_count = (CMP_W'(cfg.glyph_count) > CMP_W'(MAX_GLYPHS))
		? CMP_W'(MAX_GLYPHS) : CMP_W'(cfg.glyph_count);
	assign cur_blank = (glyph_index_q == '0) || (CMP_W'(glyph_index_q) > eff_count);
	assign nxt_blank = CMP_W'(nxt_slot) > eff_count;
	assign idx_next  = CMP_W'(glyph_index_q) + CMP_W'(1);

	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign scroll      = (scan_column_q == 3'd0) && (elapsed_inc >= cfg.scroll_period_ticks);

	// Each row is the current glyph row shifted right with the next glyph
	// filling in from the left.
	always_comb begin
		pair = '0;
		for (int r = 0; r < LMSS_ROWS; r++) begin
			pair = {nxt_blank ? 8'h00 : nxt_rows[r], cur_blank ? 8'h00 : cur_rows[r]};
			pair = pair >> bit_offset_q;
			new_frame[r] = pair[7:0];
		end
	end

	assign shown_frame            = scroll ? new_frame : frame_q;
	assign result.column_select_n = ~(8'd1 << scan_column_q);
	assign result.row_drive       = shown_frame[scan_column_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_index_q <= '0;
			bit_offset_q  <= '0;
			scan_column_q <= '0;
			elapsed_q     <= '0;
			frame_q       <= '0;
		end else if (step) begin
			scan_column_q <= scan_column_q + 3'd1;
			if (scroll) begin
				elapsed_q    <= '0;
				frame_q      <= new_frame;
				bit_offset_q <= bit_offset_q + 3'd1;
				if (bit_offset_q == 3'd7) begin
					if (idx_next >= eff_count + CMP_W'(1)) begin
						glyph_index_q <= '0;
					end else begin
						glyph_index_q <= idx_next[SLOT_W-1:0];
					end
				end
			end else begin
				elapsed_q <= elapsed_inc;
			end
		end
	end

endmodule

// ----- sv/led_matrix_scroll_scanner_unit.sv -----
// An enabled tick in the request register leaves its column result in the result register.
// Throughput: one request per cycle unless a tick is held by a stalled result; the request
// and result registers are parted, so a new request is taken while a finished result waits.
// Reset (arst_n, asynchronous, active low) clears all control state, the frame image and
// the glyph store valid bits at once, so the store reads as blank with no clearing pass.
module led_matrix_scroll_scanner_unit #(
	parameter int MAX_GLYPHS = lmss_pkg::LMSS_MAX_GLYPHS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  lmss_pkg::lmss_in_t               req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output lmss_pkg::lmss_out_t              rsp_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lmss_pkg::LMSS_ADDR_W-1:0] paddr,
	input  logic [lmss_pkg::LMSS_DATA_W-1:0] pwdata,
	output logic [lmss_pkg::LMSS_DATA_W-1:0] prdata,
	output logic                             pready
);
	import lmss_pkg::*;

	localparam int SLOT_W = $clog2(MAX_GLYPHS + 2);

	lmss_cfg_t                 cfg;

	// Request register: holds the request that is being worked on.
	logic                      valid_s1;
	lmss_in_t                  req_s1;
	// Result register: holds a column result until the consumer takes it.
	logic                      rsp_valid_s2;
	lmss_out_t                 rsp_s2;

	logic                      is_tick;
	logic                      makes_rsp;
	logic                      out_free;
	logic                      s1_go;
	logic                      step;
	lmss_wr_t                  wr;
	logic [SLOT_W-1:0]         cur_slot;
	logic [SLOT_W-1:0]         nxt_slot;
	logic [LMSS_ROWS-1:0][7:0] cur_rows;
	logic [LMSS_ROWS-1:0][7:0] nxt_rows;
	lmss_out_t                 result;

	// A tick only produces a result while the display is enabled. Writes and
	// disabled ticks retire without touching the result register.
	assign is_tick   = (req_s1.action == ACT_TICK);
	assign makes_rsp = is_tick && cfg.display_enable;
	assign out_free  = !rsp_valid_s2 || rsp_ready;
	assign s1_go     = valid_s1 && (!makes_rsp || out_free);
	assign step      = s1_go && makes_rsp;
	assign req_ready = !valid_s1 || s1_go;

	// Glyph writes are applied when they retire from the request register, so
	// they stay in order with the ticks around them. The store reads through
	// a registered port and forwards a write to a read of the same entry,
	// so a tick right after a write already sees the new byte.
	assign wr.en   = s1_go && !is_tick;
	assign wr.slot = req_s1.glyph_slot;
	assign wr.row  = req_s1.glyph_row;
	assign wr.data = req_s1.glyph_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (step) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp_data  = rsp_s2;

	lmss_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lmss_glyph_store #(
		.MAX_GLYPHS (MAX_GLYPHS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.cur_slot (cur_slot),
		.nxt_slot (nxt_slot),
		.cur_rows (cur_rows),
		.nxt_rows (nxt_rows)
	);

	// The scroll position only moves at the start of a frame, so the slot
	// addresses held on the store have settled by the time the next scroll reads them.
	lmss_scan_core #(
		.MAX_GLYPHS (MAX_GLYPHS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (step),
		.cur_rows (cur_rows),
		.nxt_rows (nxt_rows),
		.cur_slot (cur_slot),
		.nxt_slot (nxt_slot),
		.result   (result)
	);

endmodule

// ----- sv/lmss_checker.sv -----
module lmss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input lmss_pkg::lmss_in_t  req_data,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input lmss_pkg::lmss_out_t rsp_data
);
	import lmss_pkg::*;

	logic       seen_q;
	logic [7:0] last_sel_q;
	logic [7:0] expect_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_sel_q <= 8'hFF;
		end else if (rsp_valid && rsp_ready) begin
			seen_q     <= 1'b1;
			last_sel_q <= rsp_data.column_select_n;
		end
	end

	// Columns are delivered in scan order starting from column zero.
	assign expect_sel = seen_q ? {last_sel_q[6:0], last_sel_q[7]} : 8'hFE;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.column_select_n == expect_sel)
		else $error("column out of scan order");

	a_rsp_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready && req_data.action == ACT_TICK, 2))
		else $error("result without a tick request");

endmodule

bind led_matrix_scroll_scanner_unit lmss_checker u_lmss_checker (.*);
